// ----- design/lrc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrc_pkg: shared types and constants of the LRU result cache
// Key layout, per-cell control word, field widths and codes.
// ----------------------------------------------------------------------------
package lrc_pkg;

    localparam int LRC_DEPTH     = 8;
    localparam int LRC_PAYLOAD_W = 64;

    localparam int LRC_KEY_W     = 32;
    localparam int LRC_VALUE_W   = 64;
    localparam int LRC_CAP_W     = 4;
    localparam int LRC_OCC_W     = 4;
    localparam int LRC_CNT_W     = 32;

    localparam int LRC_S_TDATA_W = 224;
    localparam int LRC_M_TDATA_W = 136;
    localparam int LRC_M_TUSER_W = 2;

    localparam logic [LRC_CAP_W-1:0] LRC_CAP_RESET = 4'd8;
    localparam logic [LRC_CNT_W-1:0] LRC_CNT_MAX   = 32'hFFFF_FFFF;

    // action codes
    localparam logic LRC_ACT_LOOKUP = 1'b0;
    localparam logic LRC_ACT_STORE  = 1'b1;

    // five key parts; stock sits in the lowest bits
    typedef struct packed {
        logic signed [LRC_KEY_W-1:0] delay;
        logic signed [LRC_KEY_W-1:0] lead;
        logic signed [LRC_KEY_W-1:0] reorder;
        logic signed [LRC_KEY_W-1:0] demand;
        logic signed [LRC_KEY_W-1:0] stock;
    } t_key;

    // per-cell control from the top level
    typedef struct packed {
        logic valid;  // cell holds a live entry
        logic shift;  // load from the left neighbor this cycle
    } t_cell_ctl;

endpackage

// ----- design/lrc_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrc_cell: one recency rank of the LRU chain
// Holds a key and payload, compares the key, loads from its left neighbor.
// ----------------------------------------------------------------------------
module lrc_cell #(
    parameter int PAYLOAD_WIDTH = lrc_pkg::LRC_PAYLOAD_W
) (
    input  logic                     i_clk,
    input  lrc_pkg::t_cell_ctl       i_ctl,
    input  lrc_pkg::t_key            i_probe_key,
    input  lrc_pkg::t_key            i_left_key,
    input  logic [PAYLOAD_WIDTH-1:0] i_left_payload,
    output lrc_pkg::t_key            o_key,
    output logic [PAYLOAD_WIDTH-1:0] o_payload,
    output logic                     o_match
);

    lrc_pkg::t_key            r_key;
    logic [PAYLOAD_WIDTH-1:0] r_payload;

    // advance one rank when told to
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_key     <= i_left_key;
            r_payload <= i_left_payload;
        end
    end

    assign o_match   = i_ctl.valid && (r_key == i_probe_key);
    assign o_key     = r_key;
    assign o_payload = r_payload;

endmodule

// ----- design/lru_result_cache_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_result_cache_unit: fully associative LRU cache of result words
// A word's result sits in the output register in the cycle after accept.
// Throughput: one word per cycle; every cell compares in parallel and the
//   chain shifts in the accept cycle, so the output register alone can stall.
// Reset (synchronous, active low): occupancy, hit/miss counters and the
//   output valid clear, capacity returns to 8; no clearing pass is needed.
// ----------------------------------------------------------------------------
module lru_result_cache_unit #(
    parameter int DEPTH         = lrc_pkg::LRC_DEPTH,
    parameter int PAYLOAD_WIDTH = lrc_pkg::LRC_PAYLOAD_W
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration: capacity_limit
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [lrc_pkg::LRC_CAP_W-1:0]      i_cfg_data,
    // input words
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // stock_key, demand_key, reorder_key, lead_key, delay_key, store_value
    input  logic [lrc_pkg::LRC_S_TDATA_W-1:0]  i_s_tdata,
    // action
    input  logic                               i_s_tuser,
    // result words
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // value_out, occupancy, hit_total, miss_total, zero pad
    output logic [lrc_pkg::LRC_M_TDATA_W-1:0]  o_m_tdata,
    // found, evicted
    output logic [lrc_pkg::LRC_M_TUSER_W-1:0]  o_m_tuser
);

    // The chain is kept in recency order: cell 0 is the most recent entry,
    // and live entries always form a prefix of r_count cells. A hit at rank h
    // rotates cells 0..h (hit entry to the front); an insert shifts the live
    // prefix down by one and drops the last entry when evicting.

    localparam int IDXW = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > lrc_pkg::LRC_CAP_W) ? CW : lrc_pkg::LRC_CAP_W;

    // ---- registers --------------------------------------------------------
    logic [lrc_pkg::LRC_CAP_W-1:0]   r_cap;
    logic [CW-1:0]                   r_count, n_count;
    logic [lrc_pkg::LRC_CNT_W-1:0]   r_hit_total, n_hit_total;
    logic [lrc_pkg::LRC_CNT_W-1:0]   r_miss_total, n_miss_total;
    logic                            r_out_valid;
    logic                            r_found;
    logic                            r_evicted;
    logic [lrc_pkg::LRC_VALUE_W-1:0] r_value;
    logic [lrc_pkg::LRC_OCC_W-1:0]   r_occ;

    // ---- input unpacking --------------------------------------------------
    logic                     w_accept;
    logic                     w_store;
    lrc_pkg::t_key            w_key;
    logic [PAYLOAD_WIDTH-1:0] w_store_value;

    assign o_s_tready    = !r_out_valid || i_m_tready;
    assign w_accept      = i_s_tvalid && o_s_tready;
    assign w_store       = (i_s_tuser == lrc_pkg::LRC_ACT_STORE);
    assign w_key         = i_s_tdata[5*lrc_pkg::LRC_KEY_W-1:0];
    assign w_store_value = i_s_tdata[5*lrc_pkg::LRC_KEY_W +: PAYLOAD_WIDTH];

    // ---- cell chain -------------------------------------------------------
    lrc_pkg::t_key            w_cell_key     [DEPTH];
    logic [PAYLOAD_WIDTH-1:0] w_cell_payload [DEPTH];
    logic [DEPTH-1:0]         w_match;
    lrc_pkg::t_cell_ctl       w_ctl          [DEPTH];
    logic [PAYLOAD_WIDTH-1:0] w_head_payload;
    logic [IDXW-1:0]          w_limit;
    logic                     w_shift_en;

    for (genvar j = 0; j < DEPTH; j++) begin : g_cell
        assign w_ctl[j].valid = (CW'(j) < r_count);
        assign w_ctl[j].shift = w_shift_en && (IDXW'(j) <= w_limit);

        if (j == 0) begin : g_head
            lrc_cell #(
                .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
            ) u_cell (
                .i_clk          (i_clk),
                .i_ctl          (w_ctl[j]),
                .i_probe_key    (w_key),
                .i_left_key     (w_key),
                .i_left_payload (w_head_payload),
                .o_key          (w_cell_key[j]),
                .o_payload      (w_cell_payload[j]),
                .o_match        (w_match[j])
            );
        end else begin : g_body
            lrc_cell #(
                .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
            ) u_cell (
                .i_clk          (i_clk),
                .i_ctl          (w_ctl[j]),
                .i_probe_key    (w_key),
                .i_left_key     (w_cell_key[j-1]),
                .i_left_payload (w_cell_payload[j-1]),
                .o_key          (w_cell_key[j]),
                .o_payload      (w_cell_payload[j]),
                .o_match        (w_match[j])
            );
        end
    end

    // ---- hit encode and payload select ------------------------------------
    // keys are unique in the chain, so at most one match bit is set and an
    // OR of the matching ranks and payloads is exact
    logic                     w_hit;
    logic [IDXW-1:0]          w_hit_idx;
    logic [PAYLOAD_WIDTH-1:0] w_hit_payload;

    always_comb begin
        w_hit_idx     = '0;
        w_hit_payload = '0;
        for (int j = 0; j < DEPTH; j++) begin
            if (w_match[j]) begin
                w_hit_idx     = w_hit_idx | IDXW'(j);
                w_hit_payload = w_hit_payload | w_cell_payload[j];
            end
        end
    end

    assign w_hit = |w_match;

    // front cell takes the probe key; on a lookup hit the stored payload
    // rides along, on a store the new payload
    assign w_head_payload = w_store ? w_store_value : w_hit_payload;

    // ---- capacity and eviction --------------------------------------------
    logic [CMPW-1:0] w_eff_cap;
    logic [CMPW-1:0] w_count_ext;
    logic            w_store_miss;
    logic            w_evict;

    always_comb begin
        w_eff_cap = CMPW'(r_cap);
        if (r_cap == '0) begin
            w_eff_cap = CMPW'(1);
        end else if (CMPW'(r_cap) > CMPW'(DEPTH)) begin
            w_eff_cap = CMPW'(DEPTH);
        end
    end

    assign w_count_ext  = CMPW'(r_count);
    assign w_store_miss = w_store && !w_hit;
    // a missing store at or above capacity drops the oldest (last live) cell
    assign w_evict      = w_store_miss && (w_count_ext >= w_eff_cap);

    // deepest cell that loads this cycle
    always_comb begin
        if (w_hit) begin
            w_limit = w_hit_idx;
        end else if (w_evict) begin
            w_limit = IDXW'(r_count - CW'(1));
        end else begin
            w_limit = IDXW'(r_count);
        end
    end

    assign w_shift_en = w_accept && (w_hit || w_store);

    // ---- occupancy and counters -------------------------------------------
    always_comb begin
        n_count      = r_count;
        n_hit_total  = r_hit_total;
        n_miss_total = r_miss_total;
        if (w_store_miss && !w_evict) begin
            n_count = r_count + CW'(1);
        end
        if (!w_store) begin
            if (w_hit) begin
                if (r_hit_total != lrc_pkg::LRC_CNT_MAX) begin
                    n_hit_total = r_hit_total + lrc_pkg::LRC_CNT_W'(1);
                end
            end else if (r_miss_total != lrc_pkg::LRC_CNT_MAX) begin
                n_miss_total = r_miss_total + lrc_pkg::LRC_CNT_W'(1);
            end
        end
    end

    logic [CMPW-1:0] w_next_count_ext;
    assign w_next_count_ext = CMPW'(n_count);

    // ---- state registers --------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap        <= lrc_pkg::LRC_CAP_RESET;
            r_count      <= '0;
            r_hit_total  <= '0;
            r_miss_total <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_cap <= i_cfg_data;
            end
            if (w_accept) begin
                r_count      <= n_count;
                r_hit_total  <= n_hit_total;
                r_miss_total <= n_miss_total;
            end
        end
    end

    // ---- output register --------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // payload of the result: hold while stalled, load on accept
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_found   <= w_hit;
            r_evicted <= w_evict;
            r_value   <= (!w_store && w_hit) ?
                         lrc_pkg::LRC_VALUE_W'(w_hit_payload) : '0;
            r_occ     <= w_next_count_ext[lrc_pkg::LRC_OCC_W-1:0];
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_valid;
    // counters are shown as they stood after the word in the output register
    assign o_m_tdata   = {4'b0000, r_miss_total, r_hit_total, r_occ, r_value};
    assign o_m_tuser   = {r_evicted, r_found};

    // ---- assertions -------------------------------------------------------
    a_match_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_match))
        else $error("more than one cell matched the key");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMPW'(r_count) <= CMPW'(DEPTH))
        else $error("occupancy above depth");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_store_miss && !w_evict) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("insert without eviction did not add an entry");

    a_evict_only_store_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tuser[0] && o_m_tuser[1]))
        else $error("result flags both found and evicted");

endmodule
